### rtl/core/tamc_pkg.sv
// Shared types, widths and codes for the texel alpha mode classifier.
`timescale 1ns / 1ps

package tamc_pkg;

  // Fixed-point format of channels, coefficients and alpha.
  localparam int FRAC_BITS = 16;
  localparam int CHAN_W    = 20;
  localparam int NUM_CHAN  = 4;
  localparam int CHAN_SEL_W = $clog2(NUM_CHAN);

  // Stream payload widths.
  localparam int IN_TDATA_W  = NUM_CHAN * CHAN_W;
  localparam int OUT_COUNT_W = 24;
  localparam int DEC_W       = 2;
  localparam int OUT_TDATA_W = ((DEC_W + 3 * OUT_COUNT_W + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 20;
  localparam int CCOUNT_W    = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_COEF_RED     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_GREEN   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_BLUE    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_ALPHA   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_OFFSET = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CONST_FACTOR = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_CHAN_COUNT   = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_BYTE_FORMAT  = 3'd7;

  // Decision codes.
  localparam logic [DEC_W-1:0] DEC_KEEP_BLEND = 2'd0;
  localparam logic [DEC_W-1:0] DEC_OPAQUE     = 2'd1;
  localparam logic [DEC_W-1:0] DEC_MASK       = 2'd2;

  localparam int DEFAULT_COUNT_BITS = 24;

  // Datapath widths: accumulator of four 20x20 products, pre-scale alpha,
  // shared multiplier product and final rounded alpha.
  localparam int ACC_W   = 2 * CHAN_W + 2;
  localparam int ALPHA_W = ACC_W - FRAC_BITS + 1;
  localparam int PROD_W  = ALPHA_W + CHAN_W;
  localparam int FIN_W   = PROD_W - FRAC_BITS;

  localparam longint ONE_Q   = longint'(1) << FRAC_BITS;
  localparam longint HALF_Q  = longint'(1) << (FRAC_BITS - 1);
  localparam longint T_MAX_Q = (longint'(3) << FRAC_BITS) / 510;
  localparam longint O_MIN_Q = ONE_Q - T_MAX_Q;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                  load;      // capture the input beat, clear the accumulator
    logic                  mul;       // shared multiplier computes a product
    logic                  scale;     // multiplier operands: alpha and constant factor
    logic [CHAN_SEL_W-1:0] sel;       // channel for the dot product
    logic                  acc_en;    // add the last product to the accumulator
    logic                  round_en;  // round the sum and add the offset
    logic                  count_en;  // classify alpha and update the counters
    logic                  report;    // load the result register, clear the counters
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

endpackage

### rtl/core/tamc_ctrl.sv
// Controller state machine sequencing one texel through the shared multiplier.
`timescale 1ns / 1ps

module tamc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  tamc_pkg::status_t  status,
  output tamc_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_ACC,
    ST_ROUND,
    ST_SCALE,
    ST_COUNT,
    ST_REPORT
  } state_t;

  state_t                              state;
  state_t                              state_next;
  logic [tamc_pkg::CHAN_SEL_W-1:0]     cnt;
  logic                                can_load;

  assign in_ready = (state == ST_IDLE) && !rst;
  assign can_load = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    cmd.sel    = cnt;
    state_next = state;
    case (state)
      ST_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        cmd.mul    = 1'b1;
        cmd.acc_en = (cnt != '0);
        if (cnt == tamc_pkg::CHAN_SEL_W'(tamc_pkg::NUM_CHAN - 1)) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc_en = 1'b1;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        state_next   = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.mul    = 1'b1;
        cmd.scale  = 1'b1;
        state_next = ST_COUNT;
      end
      ST_COUNT: begin
        cmd.count_en = 1'b1;
        state_next   = status.last ? ST_REPORT : ST_IDLE;
      end
      ST_REPORT: begin
        // The previous report must have left the result register first.
        cmd.report = can_load;
        if (can_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_MAC) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (cmd.report) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/tamc_datapath.sv
// Datapath: configuration registers, shared multiplier, accumulator and counters.
`timescale 1ns / 1ps

module tamc_datapath #(
  parameter int COUNT_BITS = tamc_pkg::DEFAULT_COUNT_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [tamc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tamc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [tamc_pkg::IN_TDATA_W-1:0]      in_data,
  input  logic                                 in_last,
  input  tamc_pkg::cmd_t                       cmd,
  output tamc_pkg::status_t                    status,
  output logic [tamc_pkg::OUT_TDATA_W-1:0]     out_data
);

  localparam int CW  = tamc_pkg::CHAN_W;
  localparam int DW  = COUNT_BITS + 8;
  localparam int PAD = tamc_pkg::OUT_TDATA_W - tamc_pkg::DEC_W - 3 * tamc_pkg::OUT_COUNT_W;

  localparam logic signed [tamc_pkg::FIN_W-1:0] T_MAX_S = tamc_pkg::FIN_W'(tamc_pkg::T_MAX_Q);
  localparam logic signed [tamc_pkg::FIN_W-1:0] O_MIN_S = tamc_pkg::FIN_W'(tamc_pkg::O_MIN_Q);
  localparam logic [COUNT_BITS-1:0]             CNT_MAX = '1;

  // Byte b scaled to Q.16 with rounding: b * 65536 / 255 = b * 257 + b / 255,
  // so the rounded quotient is b * 257 plus one when b is 128 or more.
  function automatic logic signed [CW-1:0] byte_to_q(input logic [7:0] b);
    return CW'({b, b}) + CW'(b[7]);
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

  // Configuration.
  logic signed [CW-1:0]                coef [tamc_pkg::NUM_CHAN];
  logic signed [CW-1:0]                offset;
  logic signed [CW-1:0]                factor;
  logic [tamc_pkg::CCOUNT_W-1:0]       chan_count;
  logic                                byte_format;

  // Working registers.
  logic signed [CW-1:0]                chan [tamc_pkg::NUM_CHAN];
  logic                                last;
  logic signed [tamc_pkg::PROD_W-1:0]  prod;
  logic signed [tamc_pkg::ACC_W-1:0]   acc;
  logic signed [tamc_pkg::ALPHA_W-1:0] alpha;
  logic [COUNT_BITS-1:0]               seen_total;
  logic [COUNT_BITS-1:0]               seen_transparent;
  logic [COUNT_BITS-1:0]               seen_opaque;

  logic [tamc_pkg::CCOUNT_W-1:0]       nc_eff;
  logic signed [CW-1:0]                chan_val;
  logic signed [tamc_pkg::ALPHA_W-1:0] op_a;
  logic signed [CW-1:0]                op_b;
  logic signed [tamc_pkg::ACC_W-1:0]   acc_bias;
  logic signed [tamc_pkg::ACC_W-tamc_pkg::FRAC_BITS-1:0] acc_rnd;
  logic signed [tamc_pkg::PROD_W-1:0]  prod_bias;
  logic signed [tamc_pkg::FIN_W-1:0]   alpha_fin;
  logic                                is_trans;
  logic                                is_opq;
  logic [DW-1:0]                       to_sum;
  logic [DW-1:0]                       tot_ext;
  logic [DW-1:0]                       to_x100;
  logic [DW-1:0]                       tot_x99;
  logic [tamc_pkg::DEC_W-1:0]          decision;

  assign status.last = last;

  // Channel count outside one to four is clamped.
  always_comb begin
    if (chan_count == '0) begin
      nc_eff = tamc_pkg::CCOUNT_W'(1);
    end else if (chan_count > tamc_pkg::CCOUNT_W'(tamc_pkg::NUM_CHAN)) begin
      nc_eff = tamc_pkg::CCOUNT_W'(tamc_pkg::NUM_CHAN);
    end else begin
      nc_eff = chan_count;
    end
  end

  // Missing channels are zero, except alpha which is one.
  always_comb begin
    if (tamc_pkg::CCOUNT_W'(cmd.sel) < nc_eff) begin
      chan_val = byte_format ? byte_to_q(chan[cmd.sel][7:0]) : chan[cmd.sel];
    end else if (cmd.sel == tamc_pkg::CHAN_SEL_W'(tamc_pkg::NUM_CHAN - 1)) begin
      chan_val = CW'(tamc_pkg::ONE_Q);
    end else begin
      chan_val = '0;
    end
  end

  assign op_a = cmd.scale ? alpha : tamc_pkg::ALPHA_W'(chan_val);
  assign op_b = cmd.scale ? factor : coef[cmd.sel];

  // Round half up by adding one half and flooring.
  assign acc_bias  = acc + tamc_pkg::ACC_W'(tamc_pkg::HALF_Q);
  assign acc_rnd   = acc_bias[tamc_pkg::ACC_W-1:tamc_pkg::FRAC_BITS];
  assign prod_bias = prod + tamc_pkg::PROD_W'(tamc_pkg::HALF_Q);
  assign alpha_fin = prod_bias[tamc_pkg::PROD_W-1:tamc_pkg::FRAC_BITS];
  assign is_trans  = (alpha_fin <= T_MAX_S);
  assign is_opq    = (alpha_fin >= O_MIN_S);

  // Mask test: 100 * (transparent + opaque) >= 99 * total, by shifts and adds.
  assign to_sum  = DW'(seen_transparent) + DW'(seen_opaque);
  assign tot_ext = DW'(seen_total);
  assign to_x100 = (to_sum << 6) + (to_sum << 5) + (to_sum << 2);
  assign tot_x99 = (tot_ext << 6) + (tot_ext << 5) + (tot_ext << 1) + tot_ext;

  always_comb begin
    if (seen_opaque == seen_total) begin
      decision = tamc_pkg::DEC_OPAQUE;
    end else if ((seen_transparent != '0) && (to_x100 >= tot_x99)) begin
      decision = tamc_pkg::DEC_MASK;
    end else begin
      decision = tamc_pkg::DEC_KEEP_BLEND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef[0]     <= '0;
      coef[1]     <= '0;
      coef[2]     <= '0;
      coef[3]     <= CW'(tamc_pkg::ONE_Q);
      offset      <= '0;
      factor      <= CW'(tamc_pkg::ONE_Q);
      chan_count  <= tamc_pkg::CCOUNT_W'(tamc_pkg::NUM_CHAN);
      byte_format <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        tamc_pkg::REG_COEF_RED:     coef[0]     <= cfg_data;
        tamc_pkg::REG_COEF_GREEN:   coef[1]     <= cfg_data;
        tamc_pkg::REG_COEF_BLUE:    coef[2]     <= cfg_data;
        tamc_pkg::REG_COEF_ALPHA:   coef[3]     <= cfg_data;
        tamc_pkg::REG_ALPHA_OFFSET: offset      <= cfg_data;
        tamc_pkg::REG_CONST_FACTOR: factor      <= cfg_data;
        tamc_pkg::REG_CHAN_COUNT:   chan_count  <= cfg_data[tamc_pkg::CCOUNT_W-1:0];
        tamc_pkg::REG_BYTE_FORMAT:  byte_format <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < tamc_pkg::NUM_CHAN; i++) begin
        chan[i] <= in_data[i*CW +: CW];
      end
      last <= in_last;
    end
    if (cmd.mul) begin
      prod <= op_a * op_b;
    end
    if (cmd.load) begin
      acc <= '0;
    end else if (cmd.acc_en) begin
      acc <= acc + tamc_pkg::ACC_W'(prod);
    end
    if (cmd.round_en) begin
      alpha <= tamc_pkg::ALPHA_W'(acc_rnd) + tamc_pkg::ALPHA_W'(offset);
    end
    if (cmd.report) begin
      out_data <= {PAD'(0),
                   tamc_pkg::OUT_COUNT_W'(seen_total),
                   tamc_pkg::OUT_COUNT_W'(seen_opaque),
                   tamc_pkg::OUT_COUNT_W'(seen_transparent),
                   decision};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_total       <= '0;
      seen_transparent <= '0;
      seen_opaque      <= '0;
    end else if (cmd.report) begin
      seen_total       <= '0;
      seen_transparent <= '0;
      seen_opaque      <= '0;
    end else if (cmd.count_en) begin
      seen_total <= sat_inc(seen_total);
      if (is_trans) begin
        seen_transparent <= sat_inc(seen_transparent);
      end else if (is_opq) begin
        seen_opaque <= sat_inc(seen_opaque);
      end
    end
  end

endmodule

### rtl/core/texel_alpha_mode_classifier.sv
// Top level of the texel alpha mode classifier: controller, datapath and checks.
`timescale 1ns / 1ps

// Usage
// The slave stream takes one texel per beat: four 20-bit channels in tdata and
// tlast on the final texel of an image. Each texel's alpha is the weighted sum
// of its channels plus an offset, scaled by a constant factor, and is counted
// as transparent, opaque or neither. The beat carrying tlast produces one
// master beat with the decision and the three counts; other texels produce none.
// The configuration channel writes one register per beat and is ready whenever
// reset is low; it should be written only while the block is idle.
// Sequence: after the accept, a texel passes the states MAC, ACC, ROUND, SCALE
// and COUNT; the single shared 20x27 multiplier is used once per channel and
// once for the factor. The last texel of an image then passes a REPORT state,
// which loads the registered report. No new texel is taken until the last is through.
// A finished report waits in the output register; the next texel is accepted
// meanwhile, and only a following last texel waits for the register to empty.
// Reset restores the register defaults, clears the counters and drops any
// pending report.

module texel_alpha_mode_classifier #(
  parameter int COUNT_BITS = tamc_pkg::DEFAULT_COUNT_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // chan_zero [19:0], chan_one [39:20], chan_two [59:40], chan_three [79:60]
  input  logic [tamc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // decision [1:0], transparent_count [25:2], opaque_count [49:26],
  // total_count [73:50], zero [79:74]
  output logic [tamc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tamc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tamc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  tamc_pkg::cmd_t    cmd;
  tamc_pkg::status_t status;

  assign cfg_ready = !rst;

  tamc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  tamc_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .cmd       (cmd),
    .status    (status),
    .out_data  (m_axis_tdata)
  );

  // Only one texel is in flight: after a beat is taken the input closes.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted a second texel while one is in flight");

  // A report is only produced for a texel marked last.
  a_report_on_last: assert property (@(posedge clk) disable iff (rst)
    cmd.report |-> status.last)
    else $error("report issued for a texel not marked last");

  // A report never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !cmd.report)
    else $error("pending report overwritten");

  // The decision field carries only defined codes.
  a_decision_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[1:0] == tamc_pkg::DEC_KEEP_BLEND ||
                       m_axis_tdata[1:0] == tamc_pkg::DEC_OPAQUE ||
                       m_axis_tdata[1:0] == tamc_pkg::DEC_MASK))
    else $error("undefined decision code on output");

endmodule
